// ===== sv/gtpd_pkg.sv =====
// ----------------------------------------------------------------------------
// gtpd_pkg
// Shared types, constants and the hat direction table for the gameport
// triplet packet decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package gtpd_pkg;

	// Triplet store limits
	localparam int MaxTriplets   = 80;
	// only triplets 0..26 carry packet bits 0..80 that the decoder reads
	localparam int StoreTriplets = 27;
	localparam int PktBits       = 3 * StoreTriplets;
	localparam int CountW        = 7;
	localparam int TimeW         = 16;
	localparam int StrobeBit     = 4;

	// Queue between front and back
	localparam int FifoDepth = 2;
	localparam int FifoPtrW  = $clog2(FifoDepth);
	localparam int FifoCntW  = $clog2(FifoDepth + 1);

	// Register reset values
	localparam logic [TimeW-1:0]  StartTimeoutRst  = 16'd400;
	localparam logic [TimeW-1:0]  StrobeTimeoutRst = 16'd40;
	localparam logic [CountW-1:0] PacketLengthRst  = 7'd40;

	// APB register map
	localparam int AddrW = 4;
	localparam int DataW = 32;

	typedef enum logic [1:0] {
		RegStartTimeout  = 2'd0,
		RegStrobeTimeout = 2'd1,
		RegPacketLength  = 2'd2
	} reg_idx_t;

	// Item mode codes
	localparam logic ModeTrigger = 1'b0;
	localparam logic ModeSample  = 1'b1;

	typedef struct packed {
		logic [TimeW-1:0]  start_timeout;
		logic [TimeW-1:0]  strobe_timeout;
		logic [CountW-1:0] packet_length;
	} cfg_t;

	// One finished packet as handed from front to back
	typedef struct packed {
		logic               status;
		logic [PktBits-1:0] bits;
		logic [CountW-1:0]  count;
	} pkt_t;

	// Hat direction table: returns {x, y}, each 2-bit signed
	function automatic logic [3:0] hat_lookup(input logic [3:0] idx);
		logic [3:0] r;
		begin
			case (idx)
				4'd1:    r = {2'sb00, 2'sb11};
				4'd2:    r = {2'sb01, 2'sb11};
				4'd3:    r = {2'sb01, 2'sb00};
				4'd4:    r = {2'sb01, 2'sb01};
				4'd5:    r = {2'sb00, 2'sb01};
				4'd6:    r = {2'sb11, 2'sb01};
				4'd7:    r = {2'sb11, 2'sb00};
				4'd8:    r = {2'sb11, 2'sb11};
				default: r = {2'sb00, 2'sb00}; // index 0 and codes above eight: centred
			endcase
			return r;
		end
	endfunction

endpackage

`default_nettype wire

// ===== sv/gtpd_front.sv =====
// ----------------------------------------------------------------------------
// gtpd_front
// Takes trigger and sample items, detects strobe edges, stores triplets,
// runs the tick budget and hands each finished packet to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module gtpd_front (
	input  wire                        clk,
	input  wire                        arst_n,
	input  gtpd_pkg::cfg_t             cfg,
	input  wire                        accept,
	input  wire                        mode,
	input  wire [7:0]                  port_byte,
	output logic                       push,
	output gtpd_pkg::pkt_t             push_pkt
);
	import gtpd_pkg::*;

	logic [2:0]        store_q [StoreTriplets];
	logic [2:0]        store_nxt [StoreTriplets];
	logic [7:0]        prev_q;
	logic [TimeW-1:0]  ticks_q;
	logic [CountW-1:0] count_q;
	logic              capturing_q;

	logic              trigger;
	logic              tick;
	logic              strobe_edge;
	logic              wr_triplet;
	logic [TimeW-1:0]  ticks_dec;
	logic [TimeW-1:0]  ticks_nxt;
	logic [TimeW-1:0]  start_eff;
	logic [TimeW-1:0]  strobe_eff;
	logic [CountW-1:0] count_nxt;
	logic [CountW-1:0] len_eff;
	logic              done_full;
	logic              done_to;

	// Effective register values: zero timeout is one tick, length clamps 1..max
	always_comb begin
		start_eff  = (cfg.start_timeout == '0) ? TimeW'(1) : cfg.start_timeout;
		strobe_eff = (cfg.strobe_timeout == '0) ? TimeW'(1) : cfg.strobe_timeout;
		if (cfg.packet_length == '0) begin
			len_eff = CountW'(1);
		end else if (cfg.packet_length > CountW'(MaxTriplets)) begin
			len_eff = CountW'(MaxTriplets);
		end else begin
			len_eff = cfg.packet_length;
		end
	end

	// Sample path: edge detect, count, budget
	always_comb begin
		trigger     = accept && (mode == ModeTrigger);
		tick        = accept && (mode == ModeSample) && capturing_q;
		strobe_edge = port_byte[StrobeBit] && !prev_q[StrobeBit];
		wr_triplet  = strobe_edge && (count_q < CountW'(MaxTriplets));
		ticks_dec   = (ticks_q != '0) ? ticks_q - TimeW'(1) : ticks_q;
		ticks_nxt   = strobe_edge ? strobe_eff : ticks_dec;
		count_nxt   = wr_triplet ? count_q + CountW'(1) : count_q;
		done_full   = count_nxt >= len_eff;
		done_to     = ticks_nxt == '0;
	end

	// Next store contents, including the triplet taken this tick
	always_comb begin
		for (int j = 0; j < StoreTriplets; j++) begin
			if (wr_triplet && (count_q == CountW'(j))) begin
				store_nxt[j] = port_byte[7:5];
			end else begin
				store_nxt[j] = store_q[j];
			end
		end
	end

	// Finished packet towards the queue
	always_comb begin
		push           = tick && (done_full || done_to);
		push_pkt.status = !done_full;
		push_pkt.count  = count_nxt;
		for (int j = 0; j < StoreTriplets; j++) begin
			push_pkt.bits[3*j +: 3] = store_nxt[j];
		end
	end

	// Capture state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			ticks_q     <= '0;
			count_q     <= '0;
			capturing_q <= 1'b0;
			for (int j = 0; j < StoreTriplets; j++) begin
				store_q[j] <= '0;
			end
		end else if (trigger) begin
			prev_q      <= port_byte;
			ticks_q     <= start_eff;
			count_q     <= '0;
			capturing_q <= 1'b1;
			for (int j = 0; j < StoreTriplets; j++) begin
				store_q[j] <= '0;
			end
		end else if (tick) begin
			prev_q      <= port_byte;
			ticks_q     <= ticks_nxt;
			count_q     <= count_nxt;
			capturing_q <= !(done_full || done_to);
			for (int j = 0; j < StoreTriplets; j++) begin
				store_q[j] <= store_nxt[j];
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/gtpd_fifo.sv =====
// ----------------------------------------------------------------------------
// gtpd_fifo
// Short queue of finished packets between the capture front and the
// decode back.
// ----------------------------------------------------------------------------
`default_nettype none

module gtpd_fifo (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        push,
	input  gtpd_pkg::pkt_t             push_pkt,
	input  wire                        pop,
	output gtpd_pkg::pkt_t             head_pkt,
	output logic                       full,
	output logic                       empty
);
	import gtpd_pkg::*;

	pkt_t                mem_q [FifoDepth];
	logic [FifoPtrW-1:0] wr_ptr_q;
	logic [FifoPtrW-1:0] rd_ptr_q;
	logic [FifoCntW-1:0] cnt_q;
	logic                do_push;
	logic                do_pop;

	always_comb begin
		full     = cnt_q == FifoCntW'(FifoDepth);
		empty    = cnt_q == '0;
		do_push  = push && !full;
		do_pop   = pop && !empty;
		head_pkt = mem_q[rd_ptr_q];
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_pkt;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/gtpd_back.sv =====
// ----------------------------------------------------------------------------
// gtpd_back
// Pulls finished packets from the queue, decodes axes, hat, buttons and
// device id, and holds the result item in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gtpd_back (
	input  wire                        clk,
	input  wire                        arst_n,
	input  gtpd_pkg::pkt_t             head_pkt,
	input  wire                        empty,
	output logic                       pop,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic                       status,
	output logic [9:0]                 axis_0,
	output logic [9:0]                 axis_1,
	output logic [9:0]                 axis_2,
	output logic [9:0]                 axis_3,
	output logic [9:0]                 axis_4,
	output logic [9:0]                 axis_5,
	output logic signed [1:0]          hat_x,
	output logic signed [1:0]          hat_y,
	output logic [11:0]                buttons,
	output logic [6:0]                 device_id,
	output logic [6:0]                 triplets_received
);
	import gtpd_pkg::*;

	logic [PktBits-1:0] b;
	logic [9:0]         ax [6];
	logic [3:0]         hat;
	logic [11:0]        btn;
	logic [6:0]         dev;
	logic               valid_q;

	// Field decode from the packet bit string
	always_comb begin
		b = head_pkt.bits;
		for (int i = 0; i < 4; i++) begin
			ax[i] = {b[50+i], b[46+i], b[8*i +: 8]};
		end
		for (int i = 0; i < 2; i++) begin
			ax[4+i] = {b[54+i], 1'b0, b[60+9*i +: 8]};
		end
		hat = hat_lookup(b[43:40]);
		btn = {b[79:78], b[39:32], b[45:44]};
		dev = {b[1:0], b[5:3], b[8:7]};
	end

	assign pop       = !empty && (!valid_q || out_ready);
	assign out_valid = valid_q;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= pop || (valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status            <= head_pkt.status;
			axis_0            <= ax[0];
			axis_1            <= ax[1];
			axis_2            <= ax[2];
			axis_3            <= ax[3];
			axis_4            <= ax[4];
			axis_5            <= ax[5];
			hat_x             <= hat[3:2];
			hat_y             <= hat[1:0];
			buttons           <= btn;
			device_id         <= dev;
			triplets_received <= head_pkt.count;
		end
	end

endmodule

`default_nettype wire

// ===== sv/gameport_triplet_packet_decoder_top.sv =====
// ----------------------------------------------------------------------------
// gameport_triplet_packet_decoder_top
// Joystick port triplet packet decoder: APB registers, capture front,
// packet queue and decode back.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       sink       in_valid/in_ready    mode, port_byte
//  out      source     out_valid/out_ready  status, axis_0..5, hat_x/y, buttons,
//                                           device_id, triplets_received
//  cfg      APB slave  psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// One item is taken every clock while the queue has a free entry; the capture
// front updates its state in the cycle the item is accepted. A finished packet
// is written into a two-entry queue at the edge that accepts the item that
// ended it, then loaded into the output register, raising out_valid, once that
// register is empty or being drained. in_ready falls only when both queue
// entries are held. Reset clears all capture state; registers return to 400/40/40.
// ----------------------------------------------------------------------------
`default_nettype none

module gameport_triplet_packet_decoder_top (
	input  wire                        clk,
	input  wire                        arst_n,
	// input items
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire                        mode,
	input  wire [7:0]                  port_byte,
	// result items
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic                       status,
	output logic [9:0]                 axis_0,
	output logic [9:0]                 axis_1,
	output logic [9:0]                 axis_2,
	output logic [9:0]                 axis_3,
	output logic [9:0]                 axis_4,
	output logic [9:0]                 axis_5,
	output logic signed [1:0]          hat_x,
	output logic signed [1:0]          hat_y,
	output logic [11:0]                buttons,
	output logic [6:0]                 device_id,
	output logic [6:0]                 triplets_received,
	// configuration
	input  wire                        psel,
	input  wire                        penable,
	input  wire                        pwrite,
	input  wire [gtpd_pkg::AddrW-1:0]  paddr,
	input  wire [gtpd_pkg::DataW-1:0]  pwdata,
	output logic [gtpd_pkg::DataW-1:0] prdata,
	output logic                       pready
);
	import gtpd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;
	logic     accept;
	logic     push;
	pkt_t     push_pkt;
	pkt_t     head_pkt;
	logic     pop;
	logic     full;
	logic     empty;

	// APB register port
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[AddrW-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_timeout  <= StartTimeoutRst;
			cfg_q.strobe_timeout <= StrobeTimeoutRst;
			cfg_q.packet_length  <= PacketLengthRst;
		end else if (cfg_wr) begin
			case (reg_idx)
				RegStartTimeout:  cfg_q.start_timeout  <= pwdata[TimeW-1:0];
				RegStrobeTimeout: cfg_q.strobe_timeout <= pwdata[TimeW-1:0];
				RegPacketLength:  cfg_q.packet_length  <= pwdata[CountW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			RegStartTimeout:  prdata = DataW'(cfg_q.start_timeout);
			RegStrobeTimeout: prdata = DataW'(cfg_q.strobe_timeout);
			RegPacketLength:  prdata = DataW'(cfg_q.packet_length);
			default:          prdata = '0;
		endcase
	end

	// Input handshake
	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	gtpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.accept    (accept),
		.mode      (mode),
		.port_byte (port_byte),
		.push      (push),
		.push_pkt  (push_pkt)
	);

	gtpd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_pkt (push_pkt),
		.pop      (pop),
		.head_pkt (head_pkt),
		.full     (full),
		.empty    (empty)
	);

	gtpd_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.head_pkt          (head_pkt),
		.empty             (empty),
		.pop               (pop),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.status            (status),
		.axis_0            (axis_0),
		.axis_1            (axis_1),
		.axis_2            (axis_2),
		.axis_3            (axis_3),
		.axis_4            (axis_4),
		.axis_5            (axis_5),
		.hat_x             (hat_x),
		.hat_y             (hat_y),
		.buttons           (buttons),
		.device_id         (device_id),
		.triplets_received (triplets_received)
	);

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the gameport triplet packet decoder. A queue of
// port samples and triggers feeds a valid/ready driver; a predictor built
// from the packet format decodes the same items into expected reports,
// which the monitor compares field by field. Registers are set over APB
// between phases, covering the reset-like defaults and their extremes.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import gtpd_pkg::*;

	typedef struct packed {
		logic       mode;
		logic [7:0] port;
	} port_item_t;

	typedef struct packed {
		logic              status;
		logic [5:0][9:0]   axis;
		logic signed [1:0] hat_x;
		logic signed [1:0] hat_y;
		logic [11:0]       buttons;
		logic [6:0]        device_id;
		logic [6:0]        count;
	} joy_report_t;

	// Clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #4 clk = ~clk;

	// DUT ports
	logic              in_valid  = 1'b0;
	wire               in_ready;
	logic              mode      = ModeSample;
	logic [7:0]        port_byte = 8'h00;
	wire               out_valid;
	logic              out_ready = 1'b0;
	wire               status;
	wire [9:0]         axis_0, axis_1, axis_2, axis_3, axis_4, axis_5;
	wire signed [1:0]  hat_x, hat_y;
	wire [11:0]        buttons;
	wire [6:0]         device_id;
	wire [6:0]         triplets_received;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [AddrW-1:0]  paddr     = '0;
	logic [DataW-1:0]  pwdata    = '0;
	wire [DataW-1:0]   prdata;
	wire               pready;

	gameport_triplet_packet_decoder_top DUT (.*);

	// Register mirror
	logic [15:0] cfg_start  = StartTimeoutRst;
	logic [15:0] cfg_strobe = StrobeTimeoutRst;
	logic [6:0]  cfg_length = PacketLengthRst;

	// Decoder state as the predictor sees it
	logic [2:0]  triplet_mem [MaxTriplets];
	logic [7:0]  prev_port   = 8'h00;
	logic [15:0] tick_budget = 16'd0;
	int          trip_count  = 0;
	logic        pkt_open    = 1'b0;

	joy_report_t expected_reports [$];
	port_item_t  port_items [$];
	port_item_t  next_item;

	int   queued_items  = 0;
	int   sent_items    = 0;
	int   reports_seen  = 0;
	int   short_reports = 0;
	int   mismatches    = 0;
	int   phases        = 0;
	logic steady        = 1'b0;

	function automatic int frame_length();
		int l;
		l = int'(cfg_length);
		if (l == 0)
			l = 1;
		if (l > MaxTriplets)
			l = MaxTriplets;
		return l;
	endfunction

	// {x, y} for a hat index; anything above eight is centred
	function automatic logic [3:0] hat_direction(logic [3:0] idx);
		case (idx)
			4'd1:    return {2'b00, 2'b11};
			4'd2:    return {2'b01, 2'b11};
			4'd3:    return {2'b01, 2'b00};
			4'd4:    return {2'b01, 2'b01};
			4'd5:    return {2'b00, 2'b01};
			4'd6:    return {2'b11, 2'b01};
			4'd7:    return {2'b11, 2'b00};
			4'd8:    return {2'b11, 2'b11};
			default: return {2'b00, 2'b00};
		endcase
	endfunction

	// Decode the triplet store into the expected report
	function automatic void close_packet(logic timed_out);
		logic [79:0] pb;
		logic [3:0]  hat;
		joy_report_t r;
		for (int n = 0; n < 80; n++)
			pb[n] = triplet_mem[n / 3][n % 3];
		for (int i = 0; i < 4; i++)
			r.axis[i] = {pb[50 + i], pb[46 + i], pb[8 * i +: 8]};
		for (int i = 0; i < 2; i++)
			r.axis[4 + i] = {pb[54 + i], 1'b0, pb[60 + 9 * i +: 8]};
		hat = pb[43:40];
		{r.hat_x, r.hat_y} = hat_direction(hat);
		r.status    = timed_out;
		r.buttons   = {pb[79:78], pb[39:32], pb[45:44]};
		r.device_id = {pb[1:0], pb[5:3], pb[8:7]};
		r.count     = 7'(trip_count);
		expected_reports.push_back(r);
		if (timed_out)
			short_reports++;
		pkt_open = 1'b0;
	endfunction

	// One accepted item through the capture logic
	function automatic void sample_port(logic m, logic [7:0] b);
		logic [7:0] earlier;
		if (m == ModeTrigger) begin
			foreach (triplet_mem[i])
				triplet_mem[i] = 3'd0;
			prev_port   = b;
			tick_budget = (cfg_start == 16'd0) ? 16'd1 : cfg_start;
			trip_count  = 0;
			pkt_open    = 1'b1;
		end else if (pkt_open) begin
			if (tick_budget != 16'd0)
				tick_budget--;
			earlier   = prev_port;
			prev_port = b;
			// rising strobe edge captures a triplet
			if (b[StrobeBit] && !earlier[StrobeBit]) begin
				if (trip_count < MaxTriplets) begin
					triplet_mem[trip_count] = b[7:5];
					trip_count++;
				end
				tick_budget = (cfg_strobe == 16'd0) ? 16'd1 : cfg_strobe;
			end
			if (trip_count >= frame_length())
				close_packet(1'b0);
			else if (tick_budget == 16'd0)
				close_packet(1'b1);
		end
	endfunction

	function automatic void compare_field(string name, int want, int got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("report %0d: %s expected %0d, got %0d", reports_seen, name, want, got);
		end
	endfunction

	function automatic void check_report();
		joy_report_t      r;
		logic [5:0][9:0]  got_axes;
		got_axes = {axis_5, axis_4, axis_3, axis_2, axis_1, axis_0};
		reports_seen++;
		if (expected_reports.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("report %0d: unexpected result item", reports_seen);
		end else begin
			r = expected_reports.pop_front();
			compare_field("status", r.status, status);
			for (int i = 0; i < 6; i++)
				compare_field($sformatf("axis_%0d", i), r.axis[i], got_axes[i]);
			compare_field("hat_x", int'($signed(r.hat_x)), int'(hat_x));
			compare_field("hat_y", int'($signed(r.hat_y)), int'(hat_y));
			compare_field("buttons", r.buttons, buttons);
			compare_field("device_id", r.device_id, device_id);
			compare_field("triplets_received", r.count, triplets_received);
		end
	endfunction

	// Input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				sample_port(mode, port_byte);
				sent_items++;
			end
			if (!in_valid || in_ready) begin
				if (port_items.size() != 0 && (steady || $urandom_range(0, 99) >= 9)) begin
					next_item = port_items.pop_front();
					in_valid  <= 1'b1;
					mode      <= next_item.mode;
					port_byte <= next_item.port;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_report();
			out_ready <= steady || ($urandom_range(0, 99) >= 9);
		end
	end

	// APB write, then read back
	task automatic program_reg(reg_idx_t idx, logic [DataW-1:0] val);
		logic [DataW-1:0] mask;
		mask = (idx == RegPacketLength) ? DataW'(7'h7F) : DataW'(16'hFFFF);
		@(posedge clk);
		psel   <= 1'b1;
		pwrite <= 1'b1;
		paddr  <= AddrW'(4 * int'(idx));
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			RegStartTimeout:  cfg_start  = val[15:0];
			RegStrobeTimeout: cfg_strobe = val[15:0];
			RegPacketLength:  cfg_length = val[6:0];
			default: ;
		endcase
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		compare_field("register readback", int'(val & mask), int'(prdata & mask));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(logic [15:0] start_t, logic [15:0] strobe_t, logic [6:0] len);
		program_reg(RegStartTimeout, DataW'(start_t));
		program_reg(RegStrobeTimeout, DataW'(strobe_t));
		program_reg(RegPacketLength, DataW'(len));
		phases++;
	endtask

	function automatic void push_item(logic m, logic [7:0] b);
		port_items.push_back({m, b});
		queued_items++;
	endfunction

	function automatic logic [7:0] strobe_low();
		return 8'($urandom_range(0, 255)) & 8'hEF;
	endfunction

	function automatic logic [7:0] strobe_high();
		return 8'($urandom_range(0, 255)) | 8'h10;
	endfunction

	// Well-formed packet: trigger, then strobe pulses with random triplets
	function automatic void queue_packet();
		int len, n, gap_max, gaps;
		len = frame_length();
		case ($urandom_range(0, 9))
			0, 1:    n = $urandom_range(0, len);
			2:       n = len + $urandom_range(1, 3);
			default: n = len;
		endcase
		// keep gaps under the strobe timeout, with the odd overrun
		if (cfg_strobe > 16'd4)
			gap_max = 3;
		else if (cfg_strobe > 16'd1)
			gap_max = int'(cfg_strobe) - 1;
		else
			gap_max = 1;
		push_item(ModeTrigger, 8'($urandom_range(0, 255)));
		for (int t = 0; t < n; t++) begin
			if ($urandom_range(0, 19) == 0)
				gaps = $urandom_range(1, gap_max + 2);
			else
				gaps = $urandom_range(1, gap_max);
			repeat (gaps) push_item(ModeSample, strobe_low());
			push_item(ModeSample, strobe_high());
		end
		repeat ($urandom_range(0, 3)) push_item(ModeSample, 8'($urandom_range(0, 255)));
	endfunction

	function automatic void queue_noise();
		repeat ($urandom_range(1, 8)) begin
			if ($urandom_range(0, 9) == 0)
				push_item(ModeTrigger, 8'($urandom_range(0, 255)));
			else
				push_item(ModeSample, 8'($urandom_range(0, 255)));
		end
	endfunction

	function automatic void queue_random(int target);
		int stop;
		stop = queued_items + target;
		while (queued_items < stop) begin
			if ($urandom_range(0, 99) < 80)
				queue_packet();
			else
				queue_noise();
		end
	endfunction

	// Let everything drain; finish any open packet with strobe pulses
	task automatic settle();
		do begin
			while (sent_items != queued_items)
				@(posedge clk);
			if (pkt_open) begin
				push_item(ModeSample, strobe_low());
				push_item(ModeSample, strobe_high());
			end
		end while (pkt_open);
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Stimulus sequence
	initial begin
		foreach (triplet_mem[i])
			triplet_mem[i] = 3'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: small timeouts and a four-triplet packet
		set_config(16'd3, 16'd3, 7'd4);
		push_item(ModeSample, 8'hFF);   // tick with no packet open
		push_item(ModeTrigger, 8'hFF);  // strobe already high at trigger
		push_item(ModeSample, 8'hFF);
		push_item(ModeSample, 8'h00);
		push_item(ModeSample, 8'hF0);
		push_item(ModeSample, 8'h0F);
		push_item(ModeSample, 8'h10);
		push_item(ModeSample, 8'hEF);
		push_item(ModeSample, 8'hFF);
		push_item(ModeSample, 8'h00);
		push_item(ModeSample, 8'hB0);   // full packet
		push_item(ModeSample, 8'hFF);   // ignored after the end
		push_item(ModeTrigger, 8'h00);
		push_item(ModeSample, 8'h00);
		push_item(ModeSample, 8'h00);
		push_item(ModeSample, 8'h00);   // start timeout, nothing captured
		push_item(ModeTrigger, 8'h00);
		push_item(ModeSample, 8'hF0);
		push_item(ModeTrigger, 8'h00);  // restart an open packet
		push_item(ModeSample, 8'h70);
		push_item(ModeSample, 8'h00);
		push_item(ModeSample, 8'h00);
		push_item(ModeSample, 8'h00);   // strobe timeout, short packet
		settle();

		set_config(16'd400, 16'd40, 7'd40);
		queue_random(220);
		settle();

		set_config(16'd1, 16'd1, 7'd1);
		queue_random(200);
		settle();

		set_config(16'd0, 16'd0, 7'd0);
		queue_random(200);
		settle();

		set_config(16'hFFFF, 16'hFFFF, 7'h7F);
		queue_random(200);
		settle();

		// no idling on either side here
		steady = 1'b1;
		set_config(16'd10, 16'd4, 7'd80);
		queue_random(200);
		settle();
		steady = 1'b0;

		repeat (3) begin
			set_config(16'($urandom_range(1, 60)), 16'($urandom_range(1, 8)),
				7'($urandom_range(1, 80)));
			queue_random(210);
			settle();
		end

		set_config(16'd2, 16'd2, 7'd27);
		queue_random(200);
		settle();

		if (expected_reports.size() != 0)
			mismatches += expected_reports.size();
		$display("Drove %0d input items over %0d register settings.", sent_items, phases);
		$display("Checked %0d packet reports, %0d predicted as cut short by timeout.",
			reports_seen, short_reports);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/gtpd_pkg.sv
sv/gtpd_front.sv
sv/gtpd_fifo.sv
sv/gtpd_back.sv
sv/gameport_triplet_packet_decoder_top.sv
tb/testbench.sv
